>>> sv/mlpr_pkg.sv
// ----------------------------------------------------------------------------
// mlpr_pkg
// Shared types, controller command codes and the init sequence table for the
// monochrome LCD page refresh block.
// ----------------------------------------------------------------------------
package mlpr_pkg;

    localparam int LANES    = 8;
    localparam int INIT_LEN = 14;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } mlpr_state_t;

    // one lane's share of a framebuffer byte write
    typedef struct packed {
        logic       wr;
        logic       on;
        logic [2:0] bit_sel;
    } lane_req_t;

    // what a pull produces, except the data byte read from the lanes
    typedef struct packed {
        logic       has;
        logic       data;
        logic       last;
        logic [2:0] lane;
        logic [7:0] cmd;
    } pull_info_t;

    function automatic logic [7:0] init_byte(input logic [3:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = 8'hE2;
            4'd1:    b = 8'hA2;
            4'd2:    b = 8'hA0;
            4'd3:    b = 8'hC8;
            4'd4:    b = 8'hA6;
            4'd5:    b = 8'h40;
            4'd6:    b = 8'h24;
            4'd7:    b = 8'h81;
            4'd8:    b = 8'h19;
            4'd9:    b = 8'h2C;
            4'd10:   b = 8'h2E;
            4'd11:   b = 8'h2F;
            4'd12:   b = 8'hA4;
            4'd13:   b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> sv/mono_lcd_page_refresh.sv
// ----------------------------------------------------------------------------
// mono_lcd_page_refresh
// Row-major 1-bit framebuffer to page-organized LCD controller byte stream.
// ----------------------------------------------------------------------------
// Every item, a framebuffer byte write or a pull, is taken in the idle state
// and then passes through the busy state: the page store banks are read on
// acceptance and the pixel bits are written back (or the pulled byte is
// registered) at the end of the busy state; no new item is taken before that.
// The store is split into eight banks by column modulo eight, so one write
// updates its eight pixels in parallel. After reset a clearing pass zeroes
// the store, one row per cycle over all DEPTH rows; no item is accepted
// until it ends. A pull is accepted only when the result register is empty
// or being drained; a write is accepted regardless.
module mono_lcd_page_refresh
    import mlpr_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [5:0] s_row_index,
    input  logic [3:0] s_column_byte,
    input  logic [7:0] s_pixel_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_has_byte,
    output logic [7:0] m_lcd_byte,
    output logic       m_is_data,
    output logic       m_pass_last
);

    localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
    localparam int CB    = (PANEL_WIDTH + 7) / 8;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CBW   = (CB > 1) ? $clog2(CB) : 1;
    localparam int AW    = PW + CBW;
    localparam int DEPTH = PAGES << CBW;
    localparam int SW    = $clog2(PANEL_WIDTH + 3);

    mlpr_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          dirty_reg, dirty_next;
    logic          pend_pull_reg;
    pull_info_t    info_reg;

    logic          out_valid_reg, out_valid_next;
    logic          out_has_reg;
    logic [7:0]    out_byte_reg;
    logic          out_data_reg;
    logic          out_last_reg;

    logic          accept;
    logic          pull;
    logic          wr_ok;
    logic          pass_start;
    pull_info_t    info;
    logic [PW-1:0] rd_page;
    logic [CBW-1:0] rd_cb;
    logic [AW-1:0] addr;
    logic          clr_en;

    lane_req_t     req     [LANES];
    logic [7:0]    lane_rd [LANES];
    logic [LANES-1:0] lane_chg;

    assign accept = s_valid && s_ready;
    assign pull   = accept && s_op;
    assign wr_ok  = (8'(s_row_index) < 8'(PANEL_HEIGHT));
    assign clr_en = (state_reg == ST_CLEAR);

    always_comb begin
        if (s_op) begin
            addr = {rd_page, rd_cb};
        end else begin
            addr = {PW'(s_row_index >> 3), CBW'(s_column_byte)};
        end
    end

    mlpr_seq #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PAGES       (PAGES),
        .PW          (PW),
        .CBW         (CBW),
        .SW          (SW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pull       (pull),
        .dirty      (dirty_reg),
        .pass_start (pass_start),
        .info       (info),
        .rd_page    (rd_page),
        .rd_cb      (rd_cb)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        always_comb begin
            req[k].wr      = accept && !s_op && wr_ok
                             && (9'({s_column_byte, 3'(k)}) < 9'(PANEL_WIDTH));
            req[k].on      = s_pixel_byte[k];
            req[k].bit_sel = s_row_index[2:0];
        end

        mlpr_lane #(
            .AW    (AW),
            .DEPTH (DEPTH)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req      (req[k]),
            .addr     (addr),
            .clr_en   (clr_en),
            .clr_addr (clr_cnt_reg),
            .rd_data  (lane_rd[k]),
            .changed  (lane_chg[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            dirty_reg     <= 1'b1;
            pend_pull_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            dirty_reg     <= dirty_next;
            pend_pull_reg <= pull;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pull) begin
            info_reg <= info;
        end
        if (state_reg == ST_BUSY && pend_pull_reg) begin
            out_has_reg  <= info_reg.has;
            out_data_reg <= info_reg.data;
            out_last_reg <= info_reg.last;
            // merge: take the column byte from the lane that holds it
            out_byte_reg <= info_reg.data ? lane_rd[info_reg.lane] : info_reg.cmd;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg;
        s_ready        = 1'b0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = !s_op || !out_valid_reg || m_ready;
                if (accept) begin
                    state_next = ST_BUSY;
                end
                if (pull && pass_start) begin
                    dirty_next = 1'b0;
                end
            end
            ST_BUSY: begin
                state_next = ST_IDLE;
                if (|lane_chg) begin
                    dirty_next = 1'b1;
                end
                if (pend_pull_reg) begin
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = out_valid_reg;
    assign m_has_byte  = out_has_reg;
    assign m_lcd_byte  = out_byte_reg;
    assign m_is_data   = out_data_reg;
    assign m_pass_last = out_last_reg;

endmodule

>>> sv/mlpr_lane.sv
// ----------------------------------------------------------------------------
// mlpr_lane
// One bank of the page store: holds every eighth column. Reads one column
// byte per cycle and does the single-bit read-modify-write of a pixel write.
// ----------------------------------------------------------------------------
module mlpr_lane
    import mlpr_pkg::*;
#(
    parameter int AW    = 7,
    parameter int DEPTH = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lane_req_t     req,
    input  logic [AW-1:0] addr,
    input  logic          clr_en,
    input  logic [AW-1:0] clr_addr,
    output logic [7:0]    rd_data,
    output logic          changed
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] addr_reg;
    logic          pend_reg;
    logic          on_reg;
    logic [2:0]    bit_sel_reg;
    logic [7:0]    mask;
    logic [7:0]    new_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= req.wr;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr;
        on_reg      <= req.on;
        bit_sel_reg <= req.bit_sel;
    end

    assign mask     = 8'd1 << bit_sel_reg;
    assign new_byte = on_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
    assign changed  = pend_reg && (new_byte != rd_data_reg);

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[addr];
        if (clr_en) begin
            mem[clr_addr] <= 8'h00;
        end else if (changed) begin
            mem[addr_reg] <= new_byte;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mlpr_seq.sv
// ----------------------------------------------------------------------------
// mlpr_seq
// Output stream sequencer: init sequence, then refresh passes of page
// commands and column data while the frame is dirty.
// ----------------------------------------------------------------------------
module mlpr_seq
    import mlpr_pkg::*;
#(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGES       = 8,
    parameter int PW          = 3,
    parameter int CBW         = 4,
    parameter int SW          = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pull,
    input  logic           dirty,
    output logic           pass_start,
    output pull_info_t     info,
    output logic [PW-1:0]  rd_page,
    output logic [CBW-1:0] rd_cb
);

    logic [3:0]    init_pos_reg, init_pos_next;
    logic          active_reg, active_next;
    logic [PW-1:0] page_reg, page_next;
    logic [SW-1:0] step_reg, step_next;

    logic          init_done;
    logic          eff_active;
    logic [PW-1:0] eff_page;
    logic [SW-1:0] eff_step;
    logic [SW-1:0] col;
    logic          wrap;
    logic          last_page;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_pos_reg <= '0;
            active_reg   <= 1'b0;
            page_reg     <= '0;
            step_reg     <= '0;
        end else begin
            init_pos_reg <= init_pos_next;
            active_reg   <= active_next;
            page_reg     <= page_next;
            step_reg     <= step_next;
        end
    end

    assign init_done  = (init_pos_reg == 4'(INIT_LEN));
    assign pass_start = init_done && !active_reg && dirty;
    assign eff_active = active_reg || pass_start;
    assign eff_page   = pass_start ? '0 : page_reg;
    assign eff_step   = pass_start ? '0 : step_reg;
    assign col        = eff_step - SW'(3);
    assign wrap       = (eff_step >= SW'(PANEL_WIDTH + 2));
    assign last_page  = (eff_page == PW'(PAGES - 1));
    assign rd_page    = eff_page;
    assign rd_cb      = CBW'(col >> 3);

    always_comb begin
        info.has  = !init_done || eff_active;
        info.data = init_done && eff_active && (eff_step >= SW'(3));
        info.last = init_done && eff_active && wrap && last_page;
        info.lane = col[2:0];
        if (!init_done) begin
            info.cmd = init_byte(init_pos_reg);
        end else if (!eff_active) begin
            info.cmd = 8'h00;
        end else if (eff_step == SW'(0)) begin
            info.cmd = CMD_PAGE | 8'(eff_page);
        end else if (eff_step == SW'(1)) begin
            info.cmd = CMD_COL_LO;
        end else begin
            info.cmd = CMD_COL_HI;
        end
    end

    always_comb begin
        init_pos_next = init_pos_reg;
        active_next   = active_reg;
        page_next     = page_reg;
        step_next     = step_reg;
        if (pull) begin
            if (!init_done) begin
                init_pos_next = init_pos_reg + 4'd1;
            end else if (eff_active) begin
                if (wrap) begin
                    step_next = '0;
                    if (last_page) begin
                        active_next = 1'b0;
                        page_next   = '0;
                    end else begin
                        active_next = 1'b1;
                        page_next   = eff_page + PW'(1);
                    end
                end else begin
                    active_next = 1'b1;
                    page_next   = eff_page;
                    step_next   = eff_step + SW'(1);
                end
            end
        end
    end

endmodule
